// ----- rtl/core/phs_pkg.sv -----
// Package for the polyphonic harmonic synth: sizes, state codes, shared types
// and the elaboration-time sine and note-increment tables. No dependencies.
package phs_pkg;

	localparam int MAX_VOICES   = 16;
	localparam int VOICE_W      = $clog2(MAX_VOICES);
	localparam int SAMPLE_RATE  = 48000;
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_AW      = $clog2(SINE_ENTRIES);
	localparam int HARMONICS    = 8;
	localparam int HARM_W       = $clog2(HARMONICS);
	localparam int WEIGHT_TOP   = 5 * (HARMONICS - 1);
	localparam int MIX_DIV      = WEIGHT_TOP * (HARMONICS - 1);
	localparam int NOTES        = 128;
	localparam int NOTE_W       = 7;
	localparam int FADE_W       = 16;
	localparam int SAMPLE_W     = 24;
	localparam int VSUM_W       = 24;
	localparam int ACC_W        = 48;
	localparam int DIV_NW       = 48;
	localparam int DIV_DW       = 24;
	localparam int DIV_CW       = $clog2(DIV_NW);

	localparam logic [FADE_W-1:0] FADE_RESET = 16'd4800;
	localparam logic [SAMPLE_W-1:0] OUT_MAX  = 24'h7FFFFF;
	localparam logic [SAMPLE_W:0]   OUT_MAGN = 25'h0800000;

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_TOGGLE = 1'b1;

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TG_SCAN,
		S_TG_ALLOC,
		S_VOICE,
		S_HARM,
		S_DRAIN,
		S_SCALE,
		S_FIN,
		S_DIV_START,
		S_DIV_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];
	typedef logic [31:0] inc_tab_t [NOTES];

	// Q1.15 sine via Q30 quarter-wave Taylor series, rounded half up
	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		longint unsigned u, r, x, x2, t, v;
		longint s;
		longint unsigned quad;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			u = (64'(i) << 32) / 64'(SINE_ENTRIES);
			quad = (u >> 30) & 64'd3;
			r = u & (ONE_Q30 - 64'd1);
			if (quad[0])
				r = ONE_Q30 - r;
			x = (r * PI_HALF_Q30) >> 30;
			x2 = (x * x) >> 30;
			t = x;
			s = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					s = s - longint'(t);
				else
					s = s + longint'(t);
			end
			if (s < 0)
				s = 0;
			if (s > longint'(ONE_Q30))
				s = longint'(ONE_Q30);
			v = (64'(s) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
			tab[i] = (quad >= 64'd2) ? 16'(-longint'(v)) : 16'(v);
		end
		return tab;
	endfunction

	// Phase increment per note: floor((BASE << octave) * 2^8 / SAMPLE_RATE)
	function automatic inc_tab_t build_inc();
		inc_tab_t tab;
		longint unsigned base [12];
		longint unsigned f;
		base[0]  = 64'd137167144; base[1]  = 64'd145323527; base[2]  = 64'd153964914;
		base[3]  = 64'd163120144; base[4]  = 64'd172819773; base[5]  = 64'd183096171;
		base[6]  = 64'd193983636; base[7]  = 64'd205518503; base[8]  = 64'd217739269;
		base[9]  = 64'd230686720; base[10] = 64'd244404066; base[11] = 64'd258937088;
		for (int nt = 0; nt < NOTES; nt++) begin
			f = base[nt % 12] << (nt / 12);
			tab[nt] = 32'((f << 8) / 64'(SAMPLE_RATE));
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();
	localparam inc_tab_t  NOTE_INC = build_inc();

endpackage

// ----- rtl/core/phs_if.sv -----
// Valid/ready channel interfaces for the synth's item and result streams.
// Depends on phs_pkg for field widths.
interface phs_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic [phs_pkg::NOTE_W-1:0] note;
	modport source(output valid, output kind, output note, input ready);
	modport sink(input valid, input kind, input note, output ready);
endinterface

interface phs_result_if;
	logic valid;
	logic ready;
	logic signed [phs_pkg::SAMPLE_W-1:0] sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// ----- rtl/core/phs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mix normalization.
// Depends on phs_pkg.
module phs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [phs_pkg::DIV_NW-1:0]    num,
	input  logic [phs_pkg::DIV_DW-1:0]    den,
	output phs_pkg::div_stat_t            stat,
	output logic [phs_pkg::DIV_NW-1:0]    quot
);
	logic                         busy_q, done_q;
	logic [phs_pkg::DIV_CW-1:0]   cnt_q;
	logic [phs_pkg::DIV_NW-1:0]   n_q;
	logic [phs_pkg::DIV_DW-1:0]   rem_q, den_q;
	logic [phs_pkg::DIV_DW:0]     rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q, n_q[phs_pkg::DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == phs_pkg::DIV_CW'(phs_pkg::DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[phs_pkg::DIV_NW-2:0], ge};
			rem_q <= ge ? phs_pkg::DIV_DW'(rem_sh - {1'b0, den_q})
			            : rem_sh[phs_pkg::DIV_DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = n_q;
endmodule

// ----- rtl/core/polyphonic_harmonic_synth.sv -----
// Top level of the polyphonic harmonic synth: voice table, sequencer, shared
// harmonic MAC and output register. Depends on phs_pkg, phs_if and phs_div.
//
// Sixteen-voice additive synth. A toggle transaction (kind=1) starts, fades
// out or restarts the voice for a MIDI note; it searches the voice slots in
// turn, then allocates (a matching voice ends the search early), and yields
// no result. A tick transaction (kind=0) yields one Q5.18 sample; its time
// is set by the single shared harmonic multiply-accumulate visiting every
// voice slot and eight harmonics in turn, plus the 48-step bit-serial
// normalizing divider. Items are taken one at a time; the output register
// lets the next transaction in while a sample is still waiting downstream.
// fade_length must be written through cfg_we/cfg_wdata only while idle; the
// block itself does not enforce this. Values below 2 act as 2.
module polyphonic_harmonic_synth (
	input  logic                         clk,
	input  logic                         arst_n,
	phs_item_if.sink                     item,
	phs_result_if.source                 result,
	input  logic                         cfg_we,
	input  logic [phs_pkg::FADE_W-1:0]   cfg_wdata
);
	localparam int VN = phs_pkg::MAX_VOICES;

	phs_pkg::state_t state_q, state_d;

	// voice table
	logic                          active_q [VN];
	logic                          stop_q   [VN];
	logic [phs_pkg::NOTE_W-1:0]    note_q   [VN];
	logic [phs_pkg::FADE_W-1:0]    fade_q   [VN];
	logic [31:0]                   inc_q    [VN];

	logic [phs_pkg::FADE_W-1:0]    fade_len_q;
	logic [31:0]                   time_q;
	logic [phs_pkg::VOICE_W-1:0]   vidx_q;
	logic [phs_pkg::HARM_W-1:0]    k_q;
	logic [phs_pkg::NOTE_W-1:0]    tnote_q;
	logic                          free_found_q;
	logic [phs_pkg::VOICE_W-1:0]   free_q;

	// datapath
	logic [31:0]                        base_q, ph_q, ph;
	logic signed [15:0]                 sin_s1;
	logic [5:0]                         wt_s1;
	logic                               vld_s1;
	logic signed [phs_pkg::VSUM_W-1:0]  vsum_q;
	logic signed [phs_pkg::ACC_W-1:0]   acc_q;
	logic                               neg_q;
	logic [phs_pkg::DIV_DW-1:0]         den_q;
	logic [phs_pkg::ACC_W-1:0]          mag;

	logic                               out_valid_q;
	logic signed [phs_pkg::SAMPLE_W-1:0] out_sample_q;

	logic [phs_pkg::FADE_W-1:0] top, fc, vol;
	logic                       last_voice, match, div_start;
	logic [phs_pkg::DIV_NW-1:0] div_num, quot;
	logic [phs_pkg::SAMPLE_W-1:0] res;
	phs_pkg::div_stat_t         div_stat;

	assign top = (fade_len_q < 16'd2) ? 16'd1 : fade_len_q - 16'd1;
	assign last_voice = vidx_q == phs_pkg::VOICE_W'(VN - 1);
	assign match = active_q[vidx_q] && note_q[vidx_q] == tnote_q;
	assign fc  = (fade_q[vidx_q] > top) ? top : fade_q[vidx_q];
	assign vol = stop_q[vidx_q] ? top - fc : fc;
	assign ph  = (k_q == '0) ? base_q : ph_q;
	assign mag = acc_q[phs_pkg::ACC_W-1] ? phs_pkg::ACC_W'(-acc_q) : phs_pkg::ACC_W'(acc_q);
	assign div_num = (mag << 3) + phs_pkg::DIV_NW'(den_q >> 1);
	assign div_start = state_q == phs_pkg::S_DIV_START;

	phs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	// saturate quotient into the signed sample
	always_comb begin
		if (neg_q)
			res = (quot > phs_pkg::DIV_NW'(phs_pkg::OUT_MAGN))
				? phs_pkg::OUT_MAGN[phs_pkg::SAMPLE_W-1:0]
				: phs_pkg::SAMPLE_W'(-quot);
		else
			res = (quot > phs_pkg::DIV_NW'(phs_pkg::OUT_MAX))
				? phs_pkg::OUT_MAX : quot[phs_pkg::SAMPLE_W-1:0];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			phs_pkg::S_IDLE:
				if (item.valid)
					state_d = (item.kind == phs_pkg::KIND_TOGGLE)
						? phs_pkg::S_TG_SCAN : phs_pkg::S_VOICE;
			phs_pkg::S_TG_SCAN:
				if (match)
					state_d = phs_pkg::S_IDLE;
				else if (last_voice)
					state_d = phs_pkg::S_TG_ALLOC;
			phs_pkg::S_TG_ALLOC:
				state_d = phs_pkg::S_IDLE;
			phs_pkg::S_VOICE:
				if (active_q[vidx_q])
					state_d = phs_pkg::S_HARM;
				else if (last_voice)
					state_d = phs_pkg::S_FIN;
			phs_pkg::S_HARM:
				if (k_q == phs_pkg::HARM_W'(phs_pkg::HARMONICS - 1))
					state_d = phs_pkg::S_DRAIN;
			phs_pkg::S_DRAIN:
				state_d = phs_pkg::S_SCALE;
			phs_pkg::S_SCALE:
				state_d = last_voice ? phs_pkg::S_FIN : phs_pkg::S_VOICE;
			phs_pkg::S_FIN:
				state_d = phs_pkg::S_DIV_START;
			phs_pkg::S_DIV_START:
				state_d = phs_pkg::S_DIV_WAIT;
			phs_pkg::S_DIV_WAIT:
				if (div_stat.done)
					state_d = phs_pkg::S_OUT;
			phs_pkg::S_OUT:
				if (!out_valid_q)
					state_d = phs_pkg::S_IDLE;
			default:
				state_d = phs_pkg::S_IDLE;
		endcase
	end

	assign item.ready = state_q == phs_pkg::S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= phs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_len_q   <= phs_pkg::FADE_RESET;
			time_q       <= '0;
			vidx_q       <= '0;
			k_q          <= '0;
			free_found_q <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < VN; i++) begin
				active_q[i] <= 1'b0;
				stop_q[i]   <= 1'b0;
			end
		end else begin
			if (cfg_we)
				fade_len_q <= cfg_wdata;
			vld_s1 <= state_q == phs_pkg::S_HARM;
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				phs_pkg::S_IDLE: begin
					vidx_q       <= '0;
					k_q          <= '0;
					free_found_q <= 1'b0;
				end
				phs_pkg::S_TG_SCAN: begin
					if (match) begin
						stop_q[vidx_q] <= !stop_q[vidx_q];
					end else if (!active_q[vidx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					vidx_q <= vidx_q + 1'b1;
				end
				phs_pkg::S_TG_ALLOC:
					if (free_found_q) begin
						active_q[free_q] <= 1'b1;
						stop_q[free_q]   <= 1'b0;
					end
				phs_pkg::S_VOICE:
					if (!active_q[vidx_q])
						vidx_q <= vidx_q + 1'b1;
				phs_pkg::S_HARM:
					k_q <= k_q + 1'b1;
				phs_pkg::S_SCALE: begin
					// freed once a fade-out has run its full length
					if (fade_q[vidx_q] >= top && stop_q[vidx_q])
						active_q[vidx_q] <= 1'b0;
					vidx_q <= vidx_q + 1'b1;
					k_q    <= '0;
				end
				phs_pkg::S_FIN:
					time_q <= time_q + 32'd1;
				phs_pkg::S_OUT:
					if (!out_valid_q)
						out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (vld_s1)
			vsum_q <= vsum_q + phs_pkg::VSUM_W'(signed'({1'b0, wt_s1}))
				* phs_pkg::VSUM_W'(sin_s1);
		unique case (state_q)
			phs_pkg::S_IDLE: begin
				tnote_q <= item.note;
				acc_q   <= '0;
			end
			phs_pkg::S_TG_SCAN:
				if (match)
					fade_q[vidx_q] <= '0;
				else if (!active_q[vidx_q] && !free_found_q)
					free_q <= vidx_q;
			phs_pkg::S_TG_ALLOC:
				if (free_found_q) begin
					note_q[free_q] <= tnote_q;
					fade_q[free_q] <= '0;
					inc_q[free_q]  <= phs_pkg::NOTE_INC[tnote_q];
				end
			phs_pkg::S_VOICE: begin
				base_q <= inc_q[vidx_q] * time_q;
				vsum_q <= '0;
			end
			phs_pkg::S_HARM: begin
				// harmonic k+1 phase = (k+1)*base, built by repeated add
				ph_q   <= ph + base_q;
				sin_s1 <= phs_pkg::SINE_TAB[ph[31 -: phs_pkg::SINE_AW]];
				wt_s1  <= 6'(phs_pkg::WEIGHT_TOP) - {1'b0, k_q, 2'b00};
			end
			phs_pkg::S_SCALE: begin
				acc_q <= acc_q + phs_pkg::ACC_W'(vsum_q)
					* phs_pkg::ACC_W'(signed'({1'b0, vol}));
				if (fade_q[vidx_q] < top)
					fade_q[vidx_q] <= fade_q[vidx_q] + 16'd1;
			end
			phs_pkg::S_FIN: begin
				neg_q <= acc_q[phs_pkg::ACC_W-1];
				den_q <= phs_pkg::DIV_DW'(top) * phs_pkg::DIV_DW'(phs_pkg::MIX_DIV);
			end
			phs_pkg::S_OUT:
				if (!out_valid_q)
					out_sample_q <= res;
			default: ;
		endcase
	end

	assign result.valid  = out_valid_q;
	assign result.sample = out_sample_q;

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == phs_pkg::S_DIV_WAIT)
		else $error("divider finished outside wait state");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == phs_pkg::S_OUT))
		else $error("sample loaded outside output state");
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == phs_pkg::KIND_TICK)
		|=> state_q == phs_pkg::S_VOICE && vidx_q == '0)
		else $error("tick transaction did not start voice sweep");
`endif
endmodule
